// ===== design/ljpf_pkg.sv =====
// Shared constants, types and fixed-point helpers of the Lennard-Jones pair force unit.
`timescale 1ns / 1ps
package ljpf_pkg;

  // Fixed-point formats
  localparam int unsigned LEN_FRAC = 16;
  localparam int unsigned RES_FRAC = 24;
  localparam int unsigned COORD_W  = 24;
  localparam int unsigned SQ_W     = 2 * COORD_W;
  localparam int unsigned RES_W    = 48;
  localparam int unsigned NUM_RES  = 11;
  localparam int unsigned IN_DATA_W  = 3 * COORD_W;
  localparam int unsigned OUT_DATA_W = NUM_RES * RES_W;

  // Arithmetic units
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned PROD_W  = 2 * WORD_W;
  localparam int unsigned HALF_W  = WORD_W / 2;
  localparam int unsigned MUL_LAT = 2;
  localparam int unsigned DIV_LAT = WORD_W + 1;

  // Shifts taken from the formats
  localparam int unsigned POW_SH    = 32;
  localparam int unsigned ENERGY_SH = 54 - RES_FRAC;
  localparam int unsigned W_SH      = 24;
  localparam int unsigned OUT_SH    = 32 - RES_FRAC;
  localparam int unsigned FORCE_SH  = RES_FRAC + LEN_FRAC - 32;

  // Pipeline positions, counted from the stage that holds r2
  localparam int unsigned T_S     = DIV_LAT;
  localparam int unsigned T_S2    = T_S + MUL_LAT + 1;
  localparam int unsigned T_R6    = T_S2 + MUL_LAT + 1;
  localparam int unsigned T_R12   = T_R6 + MUL_LAT + 1;
  localparam int unsigned T_DIFF  = T_R12 + 1;
  localparam int unsigned T_W     = T_DIFF + MUL_LAT + 1;
  localparam int unsigned T_EV    = T_W + 1;
  localparam int unsigned T_NUM   = T_W + MUL_LAT;
  localparam int unsigned T_Q     = T_NUM + DIV_LAT;
  localparam int unsigned LINE_LEN = T_Q + 1;
  localparam int unsigned EV_LEN   = T_Q - T_EV + 1;
  localparam int unsigned DLY_LEN  = MUL_LAT + 1;

  localparam logic [WORD_W-1:0] NEG_LIM = 64'h0000_8000_0000_0000;
  localparam logic [WORD_W-1:0] POS_LIM = 64'h0000_7FFF_FFFF_FFFF;

  // Stress component pairs: xx, yy, zz, xy, xz, yz
  localparam int unsigned NUM_PAIR = 6;
  localparam logic [1:0] PAIR_A [NUM_PAIR] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1};
  localparam logic [1:0] PAIR_B [NUM_PAIR] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

  typedef enum logic [1:0] {
    CFG_SIGMA  = 2'd0,
    CFG_EPS    = 2'd1,
    CFG_CUTOFF = 2'd2
  } cfg_reg_e;

  // Per-pair data that rides along the pipeline
  typedef struct packed {
    logic                              cnt;
    logic [2:0]                        neg;
    logic [2:0][COORD_W-1:0]           mag;
    logic [SQ_W-1:0]                   r2;
    logic [NUM_PAIR-1:0][SQ_W-1:0]     pp;
  } side_t;

  typedef struct packed {
    logic e_neg;
    logic g_neg;
  } sign_t;

  typedef struct packed {
    logic             g_neg;
    logic [RES_W-1:0] energy;
    logic [RES_W-1:0] virial;
  } ev_t;

  // floor(p / 2^sh), saturated to the word
  function automatic logic [WORD_W-1:0] sat_shr(input logic [PROD_W-1:0] p,
                                                input int unsigned sh);
    logic [PROD_W-1:0] v;
    v = p >> sh;
    return (|v[PROD_W-1:WORD_W]) ? '1 : v[WORD_W-1:0];
  endfunction

  // Apply the sign to a magnitude and saturate to the result range
  function automatic logic [RES_W-1:0] pack48(input logic neg, input logic [WORD_W-1:0] mag);
    logic [WORD_W-1:0] m;
    if (neg) begin
      m = (mag > NEG_LIM) ? NEG_LIM : mag;
      m = '0 - m;
    end else begin
      m = (mag > POS_LIM) ? POS_LIM : mag;
    end
    return m[RES_W-1:0];
  endfunction

endpackage

// ===== design/lennard_jones_pair_force.sv =====
// Top level of the Lennard-Jones 12-6 pair force unit.
//
// Pairs arrive on the s_axis channel: tdata carries offset_x, offset_y, offset_z
// (24-bit two's complement each), tuser carries species_match. Results leave on
// m_axis: tuser is in_range, tdata the eleven 48-bit force, energy, virial and
// stress words. One result word leaves for every pair word taken.
// The cfg channel writes sigma_length (index 0), well_depth (1) and
// cutoff_radius (2); other indexes are dropped. Write only while no pair is
// in flight; cfg_ready_o is always high.
// The path from acceptance to m_axis_tvalid runs through the bit-per-stage divider
// for sigma^2/r2, a chain of five 64-bit multiplies and the second divider bank for
// force and stress. Throughput is one pair per cycle while m_axis is not stalled.
// All stages move together; when the receiver stalls with a result waiting, the
// whole pipeline holds and s_axis_tready drops, so nothing is lost or repeated.
// Reset clears all valid bits and loads the default potential registers.
`timescale 1ns / 1ps
module lennard_jones_pair_force (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // offset_x [23:0], offset_y [47:24], offset_z [71:48]
  input  logic [ljpf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // species_match [0]
  input  logic [0:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // force_x, force_y, force_z, pair_energy, virial_term, stress_xx, stress_yy,
  // stress_zz, stress_xy, stress_xz, stress_yz, 48 bits each from the lowest bit up
  output logic [ljpf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // in_range [0]
  output logic [0:0]                      m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);
  import ljpf_pkg::*;

  logic               en;
  logic [COORD_W-1:0] sigma_q, cut_q;
  logic [31:0]        eps_q;

  // Register writes
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= 24'd222822;
      eps_q   <= 32'd33554432;
      cut_q   <= 24'd124518;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SIGMA:  sigma_q <= cfg_data_i[COORD_W-1:0];
        CFG_EPS:    eps_q   <= cfg_data_i;
        CFG_CUTOFF: cut_q   <= cfg_data_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: move when the output slot is empty or being taken
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Valid bits
  logic v1_q, v2_q, out_vld_q;
  logic vld_q [LINE_LEN];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      out_vld_q <= 1'b0;
      for (int k = 0; k < LINE_LEN; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      v1_q     <= s_axis_tvalid;
      v2_q     <= v1_q;
      vld_q[0] <= v2_q;
      for (int k = 1; k < LINE_LEN; k++) vld_q[k] <= vld_q[k-1];
      out_vld_q <= vld_q[T_Q];
    end
  end
  assign m_axis_tvalid = out_vld_q;

  // Front end: magnitudes, squares and cross products, r2 and range test
  logic [2:0][COORD_W-1:0]       mag1_q, mag2_q;
  logic [2:0]                    neg1_q, neg2_q;
  logic                          match1_q, match2_q;
  logic [NUM_PAIR-1:0][SQ_W-1:0] pp2_q;
  logic [SQ_W-1:0]               sig2_q, cut2_q, sig2_3_q;
  side_t                         side_d;
  side_t                         side_q [LINE_LEN];

  always_comb begin
    side_d     = '0;
    side_d.neg = neg2_q;
    side_d.mag = mag2_q;
    side_d.pp  = pp2_q;
    side_d.r2  = pp2_q[0] + pp2_q[1] + pp2_q[2];
    side_d.cnt = match2_q && (side_d.r2 != '0) && (side_d.r2 < cut2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        neg1_q[a] <= s_axis_tdata[a*COORD_W + COORD_W - 1];
        mag1_q[a] <= s_axis_tdata[a*COORD_W + COORD_W - 1]
                     ? COORD_W'(~s_axis_tdata[a*COORD_W +: COORD_W] + 1'b1)
                     : s_axis_tdata[a*COORD_W +: COORD_W];
      end
      match1_q <= s_axis_tuser[0];
      for (int k = 0; k < NUM_PAIR; k++) begin
        pp2_q[k] <= SQ_W'(mag1_q[PAIR_A[k]]) * SQ_W'(mag1_q[PAIR_B[k]]);
      end
      mag2_q   <= mag1_q;
      neg2_q   <= neg1_q;
      match2_q <= match1_q;
      sig2_q   <= SQ_W'(sigma_q) * SQ_W'(sigma_q);
      cut2_q   <= SQ_W'(cut_q) * SQ_W'(cut_q);
      sig2_3_q <= sig2_q;
      side_q[0] <= side_d;
      for (int k = 1; k < LINE_LEN; k++) side_q[k] <= side_q[k-1];
    end
  end

  // s = sigma^2 / r2 with 32 fraction bits
  logic [WORD_W-1:0] s_val;
  ljpf_div u_div_s (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({{(PROD_W-SQ_W-POW_SH){1'b0}}, sig2_3_q, {POW_SH{1'b0}}}),
    .den_i (side_q[0].r2),
    .quo_o (s_val)
  );

  // Powers: s^2, r6 = s^3, r12 = r6^2
  logic [PROD_W-1:0] prod_ss, prod_r6, prod_r12, prod_e, prod_w;
  logic [WORD_W-1:0] s2_q, r6_q, r12_q;
  logic [WORD_W-1:0] sdel_q  [DLY_LEN];
  logic [WORD_W-1:0] r6del_q [DLY_LEN];

  ljpf_mul u_mul_ss  (.clk_i(clk_i), .en_i(en), .a_i(s_val), .b_i(s_val), .prod_o(prod_ss));
  ljpf_mul u_mul_r6  (.clk_i(clk_i), .en_i(en), .a_i(s2_q), .b_i(sdel_q[DLY_LEN-1]),
                      .prod_o(prod_r6));
  ljpf_mul u_mul_r12 (.clk_i(clk_i), .en_i(en), .a_i(r6_q), .b_i(r6_q), .prod_o(prod_r12));

  // Differences r12 - r6 and r12 - r6/2 as sign and magnitude
  logic [WORD_W-1:0] half, em_q, gm_q, emag_q, w_q;
  logic [WORD_W-1:0] eps48;
  sign_t             sg_q;
  sign_t             sgd_q [DLY_LEN];
  ev_t               evd_q [EV_LEN];

  assign half  = r6del_q[DLY_LEN-1] >> 1;
  assign eps48 = (WORD_W'(eps_q) << 5) + (WORD_W'(eps_q) << 4);

  ljpf_mul u_mul_e (.clk_i(clk_i), .en_i(en), .a_i(WORD_W'(eps_q)), .b_i(em_q),
                    .prod_o(prod_e));
  ljpf_mul u_mul_w (.clk_i(clk_i), .en_i(en), .a_i(eps48), .b_i(gm_q), .prod_o(prod_w));

  always_ff @(posedge clk_i) begin
    if (en) begin
      sdel_q[0]  <= s_val;
      r6del_q[0] <= r6_q;
      sgd_q[0]   <= sg_q;
      for (int k = 1; k < DLY_LEN; k++) begin
        sdel_q[k]  <= sdel_q[k-1];
        r6del_q[k] <= r6del_q[k-1];
        sgd_q[k]   <= sgd_q[k-1];
      end
      s2_q  <= sat_shr(prod_ss, POW_SH);
      r6_q  <= sat_shr(prod_r6, POW_SH);
      r12_q <= sat_shr(prod_r12, POW_SH);
      sg_q.e_neg <= r12_q < r6del_q[DLY_LEN-1];
      em_q <= (r12_q < r6del_q[DLY_LEN-1]) ? r6del_q[DLY_LEN-1] - r12_q
                                            : r12_q - r6del_q[DLY_LEN-1];
      sg_q.g_neg <= r12_q < half;
      gm_q <= (r12_q < half) ? half - r12_q : r12_q - half;
      emag_q <= sat_shr(prod_e, ENERGY_SH);
      w_q    <= sat_shr(prod_w, W_SH);
      // Energy and virial are final here; hold them until the dividers finish
      evd_q[0].g_neg  <= sgd_q[DLY_LEN-1].g_neg;
      evd_q[0].energy <= pack48(sgd_q[DLY_LEN-1].e_neg, emag_q);
      evd_q[0].virial <= pack48(sgd_q[DLY_LEN-1].g_neg, w_q >> OUT_SH);
      for (int k = 1; k < EV_LEN; k++) evd_q[k] <= evd_q[k-1];
    end
  end

  // Force and stress numerators, then divide by r2
  logic [PROD_W-1:0] prod_f [3];
  logic [PROD_W-1:0] prod_s [NUM_PAIR];
  logic [WORD_W-1:0] qf [3];
  logic [WORD_W-1:0] qs [NUM_PAIR];

  for (genvar a = 0; a < 3; a++) begin : g_force
    ljpf_mul u_mul_f (
      .clk_i  (clk_i),
      .en_i   (en),
      .a_i    (w_q),
      .b_i    (WORD_W'(side_q[T_W].mag[a])),
      .prod_o (prod_f[a])
    );
    ljpf_div u_div_f (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (prod_f[a] << FORCE_SH),
      .den_i (side_q[T_NUM].r2),
      .quo_o (qf[a])
    );
  end

  for (genvar k = 0; k < NUM_PAIR; k++) begin : g_stress
    ljpf_mul u_mul_st (
      .clk_i  (clk_i),
      .en_i   (en),
      .a_i    (w_q),
      .b_i    (WORD_W'(side_q[T_W].pp[k])),
      .prod_o (prod_s[k])
    );
    ljpf_div u_div_st (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (prod_s[k]),
      .den_i (side_q[T_NUM].r2),
      .quo_o (qs[k])
    );
  end

  // Sign, saturate and zero out pairs that do not count
  logic [RES_W-1:0] res_d [NUM_RES];
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_user_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      res_d[a] = pack48(evd_q[EV_LEN-1].g_neg == side_q[T_Q].neg[a], qf[a]);
    end
    res_d[3] = evd_q[EV_LEN-1].energy;
    res_d[4] = evd_q[EV_LEN-1].virial;
    for (int k = 0; k < NUM_PAIR; k++) begin
      res_d[5+k] = pack48(evd_q[EV_LEN-1].g_neg ^ side_q[T_Q].neg[PAIR_A[k]]
                          ^ side_q[T_Q].neg[PAIR_B[k]], qs[k] >> OUT_SH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_user_q <= side_q[T_Q].cnt;
      for (int r = 0; r < NUM_RES; r++) begin
        out_data_q[r*RES_W +: RES_W] <= side_q[T_Q].cnt ? res_d[r] : '0;
      end
    end
  end

  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_user_q;

  // Checks
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow the output slot");

  a_accept_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted word did not enter the first stage");

  a_out_of_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("pair out of range but result not zero");

endmodule

// ===== design/ljpf_mul.sv =====
// Two-stage 64 x 64 unsigned multiplier built from four 32 x 32 partial products.
`timescale 1ns / 1ps
module ljpf_mul (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ljpf_pkg::WORD_W-1:0] a_i,
  input  logic [ljpf_pkg::WORD_W-1:0] b_i,
  output logic [ljpf_pkg::PROD_W-1:0] prod_o
);
  import ljpf_pkg::*;

  logic [WORD_W-1:0] p00_q, p01_q, p10_q, p11_q;
  logic [PROD_W-1:0] sum_q;

  // Form partial products, then add them up
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q <= WORD_W'(a_i[HALF_W-1:0]) * WORD_W'(b_i[HALF_W-1:0]);
      p01_q <= WORD_W'(a_i[HALF_W-1:0]) * WORD_W'(b_i[WORD_W-1:HALF_W]);
      p10_q <= WORD_W'(a_i[WORD_W-1:HALF_W]) * WORD_W'(b_i[HALF_W-1:0]);
      p11_q <= WORD_W'(a_i[WORD_W-1:HALF_W]) * WORD_W'(b_i[WORD_W-1:HALF_W]);
      sum_q <= {p11_q, p00_q}
             + {{HALF_W{1'b0}}, p01_q, {HALF_W{1'b0}}}
             + {{HALF_W{1'b0}}, p10_q, {HALF_W{1'b0}}};
    end
  end

  assign prod_o = sum_q;

endmodule

// ===== design/ljpf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, quotient saturated to 64 bits.
`timescale 1ns / 1ps
module ljpf_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ljpf_pkg::PROD_W-1:0] num_i,
  input  logic [ljpf_pkg::SQ_W-1:0]   den_i,
  output logic [ljpf_pkg::WORD_W-1:0] quo_o
);
  import ljpf_pkg::*;

  logic              ovf_q [DIV_LAT];
  logic [SQ_W-1:0]   rem_q [DIV_LAT];
  logic [WORD_W-1:0] lo_q  [DIV_LAT];
  logic [SQ_W-1:0]   den_q [DIV_LAT];

  logic [SQ_W:0]     trial [DIV_LAT];
  logic              ge    [DIV_LAT];

  // Compare each shifted remainder against the divisor
  always_comb begin
    trial[0] = '0;
    ge[0]    = 1'b0;
    for (int k = 1; k < DIV_LAT; k++) begin
      trial[k] = {rem_q[k-1], lo_q[k-1][WORD_W-1]};
      ge[k]    = trial[k] >= {1'b0, den_q[k-1]};
    end
  end

  // Load the high half as remainder, then shift in one quotient bit per stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= num_i[PROD_W-1:WORD_W] >= {{(WORD_W-SQ_W){1'b0}}, den_i};
      rem_q[0] <= num_i[WORD_W+SQ_W-1:WORD_W];
      lo_q[0]  <= num_i[WORD_W-1:0];
      den_q[0] <= den_i;
      for (int k = 1; k < DIV_LAT; k++) begin
        ovf_q[k] <= ovf_q[k-1];
        rem_q[k] <= ge[k] ? SQ_W'(trial[k] - {1'b0, den_q[k-1]}) : trial[k][SQ_W-1:0];
        lo_q[k]  <= {lo_q[k-1][WORD_W-2:0], ge[k]};
        den_q[k] <= den_q[k-1];
      end
    end
  end

  assign quo_o = ovf_q[DIV_LAT-1] ? '1 : lo_q[DIV_LAT-1];

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the Lennard-Jones pair force unit.
`timescale 1ns / 1ps
module tb;
  import ljpf_pkg::*;

  localparam int unsigned PIPE_DEPTH  = 149;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct {
    logic                       in_range;
    logic [NUM_RES-1:0][RES_W-1:0] words;
  } pair_result_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic [0:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  lennard_jones_pair_force dut (.*);

  // Shadow copy of the potential registers
  logic [23:0] sigma_q;
  logic [31:0] eps_q;
  logic [23:0] cutoff_q;

  pair_result_t expected_forces[$];
  int unsigned  mismatch_cnt;
  int unsigned  cycle_cnt;
  int unsigned  stall_req;
  bit           send_busy_idle;
  bit           recv_no_idle;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] sat64(input logic [127:0] v);
    return (|v[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : v[63:0];
  endfunction

  function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int unsigned sh);
    logic [127:0] wa, wb;
    wa = {64'd0, a};
    wb = {64'd0, b};
    return sat64((wa * wb) >> sh);
  endfunction

  function automatic logic [RES_W-1:0] signed48(input bit neg, input logic [63:0] m);
    logic [63:0] v;
    if (neg) begin
      v = (m > 64'h8000_0000_0000) ? 64'h8000_0000_0000 : m;
      v = 64'd0 - v;
    end else begin
      v = (m > 64'h7FFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF : m;
    end
    return v[RES_W-1:0];
  endfunction

  // Expected forces, energy, virial and stress for one pair
  function automatic pair_result_t pair_forces(input logic [IN_DATA_W-1:0] d,
                                               input logic sm);
    pair_result_t res;
    logic [63:0]  mag[3];
    bit           neg[3];
    logic [63:0]  r2, cut2, sig2, s, r6, r12, em, half, gm, w, q;
    logic [127:0] num;
    logic signed [23:0] c;
    bit e_neg, g_neg;
    int ai, bi;
    res.in_range = 1'b0;
    res.words = '0;
    r2 = 0;
    for (int a = 0; a < 3; a++) begin
      c = d[a*COORD_W +: COORD_W];
      neg[a] = c < 0;
      mag[a] = neg[a] ? 64'(-64'(c)) : 64'(c);
      r2 += mag[a] * mag[a];
    end
    cut2 = 64'(cutoff_q) * 64'(cutoff_q);
    if (!sm || r2 == 0 || r2 >= cut2) return res;
    res.in_range = 1'b1;
    sig2 = 64'(sigma_q) * 64'(sigma_q);
    s = sat64(({64'd0, sig2} << 32) / {64'd0, r2});
    r6 = mul_shr(mul_shr(s, s, 32), s, 32);
    r12 = mul_shr(r6, r6, 32);
    e_neg = r12 < r6;
    em = e_neg ? r6 - r12 : r12 - r6;
    res.words[3] = signed48(e_neg, mul_shr(64'(eps_q), em, 30));
    half = r6 >> 1;
    g_neg = r12 < half;
    gm = g_neg ? half - r12 : r12 - half;
    w = mul_shr(64'(eps_q) * 64'd48, gm, 24);
    res.words[4] = signed48(g_neg, w >> 8);
    for (int a = 0; a < 3; a++) begin
      num = ({64'd0, w} * {64'd0, mag[a]}) << 8;
      q = sat64(num / {64'd0, r2});
      res.words[a] = signed48(g_neg == neg[a], q);
    end
    for (int k = 0; k < 6; k++) begin
      ai = PAIR_A[k];
      bi = PAIR_B[k];
      num = {64'd0, w} * {64'd0, mag[ai] * mag[bi]};
      q = sat64(num / {64'd0, r2}) >> 8;
      res.words[5 + k] = signed48(g_neg ^ neg[ai] ^ neg[bi], q);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_cnt);
    mismatch_cnt++;
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    pair_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_forces.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata[63:0], 64'd0);
      end else begin
        exp_r = expected_forces.pop_front();
        if (m_axis_tuser[0] !== exp_r.in_range)
          report_mismatch("in_range", 64'(m_axis_tuser[0]), 64'(exp_r.in_range));
        for (int i = 0; i < NUM_RES; i++) begin
          if (m_axis_tdata[i*RES_W +: RES_W] !== exp_r.words[i])
            report_mismatch($sformatf("field %0d", i), 64'(m_axis_tdata[i*RES_W +: RES_W]),
                            64'(exp_r.words[i]));
        end
      end
    end
  end

  // Receiver: random gaps, quiet stretches and one long hold-off
  initial begin
    int unsigned gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (stall_req > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall_req) @(posedge clk_i);
        stall_req = 0;
      end
      gap = recv_no_idle ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_pair(input logic [23:0] x, input logic [23:0] y, input logic [23:0] z,
                           input logic sm);
    int unsigned gap;
    gap = send_busy_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    s_axis_tuser <= sm;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_forces.insert(expected_forces.size(), pair_forces({z, y, x}, sm));
  endtask

  task automatic drain_pairs();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_forces.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SIGMA:  sigma_q = val[23:0];
      CFG_EPS:    eps_q = val;
      CFG_CUTOFF: cutoff_q = val[23:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_potential(input logic [23:0] sg, input logic [31:0] ep,
                               input logic [23:0] ct);
    drain_pairs();
    write_reg(CFG_SIGMA, {8'($urandom_range(0, 255)), sg});
    write_reg(CFG_EPS, ep);
    write_reg(CFG_CUTOFF, {8'($urandom_range(0, 255)), ct});
  endtask

  // Random pair, mostly inside the cutoff sphere
  task automatic send_random_pair();
    logic [23:0] v[3];
    int unsigned span, mode, sh;
    mode = $urandom_range(0, 9);
    span = cutoff_q / 2;
    sh = $urandom_range(0, 23);
    for (int a = 0; a < 3; a++) begin
      if (mode < 6)
        v[a] = 24'($signed($urandom_range(0, 2 * span)) - $signed(span));
      else if (mode < 8)
        v[a] = 24'($urandom);
      else
        v[a] = 24'($signed($urandom) >>> (8 + sh));
    end
    send_pair(v[0], v[1], v[2], $urandom_range(0, 19) != 0);
  endtask

  task automatic test_directed();
    send_pair(24'd100000, 24'd0, 24'd0, 1'b0);
    send_pair(24'd0, 24'd0, 24'd0, 1'b1);
    send_pair(24'd124517, 24'd0, 24'd0, 1'b1);
    send_pair(24'd124518, 24'd0, 24'd0, 1'b1);
    send_pair(24'd0, 24'd200000, 24'd0, 1'b1);
    send_pair(24'd1, 24'd0, 24'd0, 1'b1);
    send_pair(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    send_pair(24'd70000, -24'd70000, 24'd3000, 1'b1);
    send_pair(-24'd90000, 24'd20000, -24'd5000, 1'b1);
    send_pair(24'd0, 24'd0, 24'd222822, 1'b1);
    set_potential(24'hFFFFFF, 32'hFFFF_FFFF, 24'hFFFFFF);
    send_pair(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
    send_pair(24'h800000, 24'h800000, 24'h800000, 1'b1);
    send_pair(24'h800000, 24'h7FFFFF, 24'd0, 1'b1);
    send_pair(24'd1, 24'hFFFFFF, 24'd0, 1'b1);
    send_pair(24'd3, 24'd2, 24'd1, 1'b0);
    drain_pairs();
    // index three is dropped
    write_reg(2'd3, 32'h0000_0001);
    send_pair(24'd65536, 24'd0, 24'd0, 1'b1);
    set_potential(24'd0, 32'd33554432, 24'd300000);
    send_pair(24'd65536, 24'd65536, 24'd0, 1'b1);
    set_potential(24'd222822, 32'd0, 24'd300000);
    send_pair(24'd250000, 24'd0, 24'd0, 1'b1);
    set_potential(24'd222822, 32'd33554432, 24'd0);
    send_pair(24'd1, 24'd0, 24'd0, 1'b1);
  endtask

  task automatic test_random_phase(input logic [23:0] sg, input logic [31:0] ep,
                                   input logic [23:0] ct, input int unsigned n);
    set_potential(sg, ep, ct);
    for (int i = 0; i < n; i++) begin
      // quiet stretches on either side now and then
      if (i % 50 == 0) begin
        send_busy_idle = $urandom_range(0, 3) == 0;
        recv_no_idle = $urandom_range(0, 3) == 0;
      end
      send_random_pair();
    end
  endtask

  // Fill the pipeline while the receiver holds off
  task automatic test_backpressure();
    set_potential(24'd222822, 32'd33554432, 24'd600000);
    send_busy_idle = 1'b1;
    stall_req = 600;
    for (int i = 0; i < 250; i++) send_random_pair();
    send_busy_idle = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_SIGMA;
    cfg_data_i = '0;
    cycle_cnt = 0;
    mismatch_cnt = 0;
    stall_req = 0;
    send_busy_idle = 1'b0;
    recv_no_idle = 1'b0;
    sigma_q = 24'd222822;
    eps_q = 32'd33554432;
    cutoff_q = 24'd124518;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random_phase(24'd222822, 32'd33554432, 24'd600000, 250);
    test_random_phase(24'd65536, 32'd16777216, 24'd200000, 200);
    test_random_phase(24'hFFFFFF, 32'hFFFF_FFFF, 24'hFFFFFF, 200);
    test_random_phase(24'd3000, 32'd1000, 24'd65536, 200);
    test_random_phase(24'($urandom), $urandom, 24'($urandom), 200);
    test_random_phase(24'd400000, 32'h8000_0000, 24'd800000, 200);
    test_random_phase(24'd222822, 32'd33554432, 24'd124518, 150);
    drain_pairs();
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
